// ===== hw/rtl/in_order_sequence_reorder_macros.svh =====
// Assertion helpers for the reorder block.
// All checks run on the rising edge of clock and are off while reset is high.
`ifndef IN_ORDER_SEQUENCE_REORDER_MACROS_SVH
`define IN_ORDER_SEQUENCE_REORDER_MACROS_SVH

// Condition that must hold at every edge.
`define IOR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Implication within the same edge.
`define IOR_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ior_pkg.sv =====
`timescale 1ns / 1ps

package ior_pkg;

   localparam int SEQ_W       = 8;
   localparam int PAYLOAD_W   = 16;
   localparam int STATUS_W    = 2;

   localparam int DEPTH_DEFAULT = 16;

   // front queue, must be a power of two
   localparam int QUEUE_DEPTH = 2;

   localparam logic [STATUS_W-1:0] STATUS_DELIVERED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PARKED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd2;

   typedef struct packed {
      logic [SEQ_W-1:0]     seq;
      logic [PAYLOAD_W-1:0] payload;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SEQ_W-1:0]     out_seq;
      logic [PAYLOAD_W-1:0] out_payload;
      logic                 last;
   } rsp_word_type;

endpackage

// ===== hw/rtl/in_order_sequence_reorder.sv =====
`timescale 1ns / 1ps
`include "in_order_sequence_reorder_macros.svh"

// In-order delivery of sequence-numbered words. A request word whose seq is
// one past the last delivered number (mod 256, reset value 0) is delivered
// with status 0, and then every parked word carrying the next number is
// delivered and freed in turn (lowest slot first on duplicates); the final
// response of the run has last set. Any other number is parked in the
// lowest free of DEPTH slots (status 1) or, with the store full, dropped
// (status 2); both give one response with last set. In the engine a parked or
// dropped word passes through S_IDLE and S_EMIT; an in-order word then goes
// through S_READ and S_EMIT once per drained entry, sharing the single store
// search and using the registered read of the payload RAM. A 2-word queue in
// front keeps accepting requests, until it fills, while a response waits for
// rsp_ready. No clearing pass after reset.
module in_order_sequence_reorder #(
   parameter int DEPTH = ior_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ior_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ior_pkg::rsp_word_type rsp_word
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                      head_valid;
   ior_pkg::req_word_type     head_word;
   logic                      head_pop;
   logic [CW-1:0]             stat_held;
   logic [DEPTH-1:0]          stat_valid;
   logic [ior_pkg::SEQ_W-1:0] stat_last;

   // front: request queue
   ior_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .head_valid (head_valid),
      .head_word  (head_word),
      .head_pop   (head_pop)
   );

   // back: classify, park, deliver and drain
   ior_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_word  (head_word),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .stat_held  (stat_held),
      .stat_valid (stat_valid),
      .stat_last  (stat_last)
   );

   // held count tracks the slot valid bits
   `IOR_ASSERT_ALWAYS(a_held_tracks_valid, stat_held == CW'($countones(stat_valid)), "held count off")
   // a delivered word always carries the last delivered number
   `IOR_ASSERT_HOLDS(a_deliver_seq, rsp_valid && (rsp_word.status == ior_pkg::STATUS_DELIVERED), rsp_word.out_seq == stat_last, "delivered seq mismatch")
   // drops only with every slot taken
   `IOR_ASSERT_HOLDS(a_drop_when_full, rsp_valid && (rsp_word.status == ior_pkg::STATUS_DROPPED), stat_held == CW'(DEPTH), "drop with free slot")
   // only a delivery run gives more than one word
   `IOR_ASSERT_HOLDS(a_chain_delivers, rsp_valid && !rsp_word.last, rsp_word.status == ior_pkg::STATUS_DELIVERED, "non-final word not a delivery")

endmodule

// ===== hw/rtl/ior_ram.sv =====
`timescale 1ns / 1ps

module ior_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ior_queue.sv =====
`timescale 1ns / 1ps

// Front part: takes request words and holds them until the engine pops.
module ior_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ior_pkg::req_word_type req_word,
   output logic                  head_valid,
   output ior_pkg::req_word_type head_word,
   input  logic                  head_pop
);

   localparam int QD  = ior_pkg::QUEUE_DEPTH;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCW = $clog2(QD + 1);

   ior_pkg::req_word_type slot_ff [QD];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic push;
   logic pop;

   assign req_ready  = (count_ff != QCW'(QD));
   assign head_valid = (count_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? QAW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QAW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule

// ===== hw/rtl/ior_engine.sv =====
`timescale 1ns / 1ps

// Back part: classifies the head word and parks, drops or delivers it; on a
// delivery, drains the store one matching entry per payload RAM round trip.
module ior_engine #(
   parameter int DEPTH = ior_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  ior_pkg::req_word_type          head_word,
   output logic                           head_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ior_pkg::rsp_word_type          rsp_word,
   output logic [$clog2(DEPTH+1)-1:0]     stat_held,
   output logic [DEPTH-1:0]               stat_valid,
   output logic [ior_pkg::SEQ_W-1:0]      stat_last
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = ior_pkg::SEQ_W;
   localparam int PW = ior_pkg::PAYLOAD_W;

   typedef enum logic [1:0] {S_IDLE, S_EMIT, S_READ} state_type;

   state_type             state_ff, state_in;
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic [SW-1:0]         seq_ff [DEPTH];
   logic [CW-1:0]         held_ff, held_in;
   logic [SW-1:0]         last_ff, last_in;
   logic [IW-1:0]         hit_ff, hit_in;
   logic                  more_ff, more_in;
   ior_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [SW-1:0]    key;
   logic [DEPTH-1:0] match;
   logic             hit_any;
   logic [IW-1:0]    hit_idx;
   logic             free_any;
   logic [IW-1:0]    free_idx;
   logic             in_order;
   logic             full;
   logic             park;
   logic             ram_rd_en;
   logic [PW-1:0]    ram_rd_data;

   // search key: number after the head word, or after the one just drained
   assign key = (state_ff == S_READ) ? SW'(last_ff + 1'b1) : SW'(head_word.seq + 1'b1);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = valid_ff[i] && (seq_ff[i] == key);
      end
   end

   // lowest index wins
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign hit_any  = |match;
   assign free_any = ~&valid_ff;
   assign in_order = (head_word.seq == SW'(last_ff + 1'b1));
   assign full     = (held_ff >= CW'(DEPTH)) || !free_any;
   assign head_pop = (state_ff == S_IDLE) && head_valid;
   assign park     = head_pop && !in_order && !full;
   assign ram_rd_en = (state_ff == S_EMIT) && rsp_ready && more_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      held_in  = held_ff;
      last_in  = last_ff;
      hit_in   = hit_ff;
      more_in  = more_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               state_in           = S_EMIT;
               rsp_in.out_seq     = head_word.seq;
               rsp_in.out_payload = head_word.payload;
               if (in_order) begin
                  last_in       = head_word.seq;
                  rsp_in.status = ior_pkg::STATUS_DELIVERED;
                  rsp_in.last   = !hit_any;
                  hit_in        = hit_idx;
                  more_in       = hit_any;
               end else if (full) begin
                  rsp_in.status = ior_pkg::STATUS_DROPPED;
                  rsp_in.last   = 1'b1;
                  more_in       = 1'b0;
               end else begin
                  valid_in[free_idx] = 1'b1;
                  held_in            = CW'(held_ff + 1'b1);
                  rsp_in.status      = ior_pkg::STATUS_PARKED;
                  rsp_in.last        = 1'b1;
                  more_in            = 1'b0;
               end
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (more_ff) begin
                  // claim the matched entry; payload arrives next cycle
                  state_in         = S_READ;
                  valid_in[hit_ff] = 1'b0;
                  held_in          = CW'(held_ff - 1'b1);
                  last_in          = SW'(last_ff + 1'b1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: begin
            state_in           = S_EMIT;
            rsp_in.status      = ior_pkg::STATUS_DELIVERED;
            rsp_in.out_seq     = last_ff;
            rsp_in.out_payload = ram_rd_data;
            rsp_in.last        = !hit_any;
            hit_in             = hit_idx;
            more_in            = hit_any;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         held_ff  <= '0;
         last_ff  <= '0;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         held_ff  <= held_in;
         last_ff  <= last_in;
         more_ff  <= more_in;
      end
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
      if (park) begin
         seq_ff[free_idx] <= head_word.seq;
      end
   end

   ior_ram #(
      .WIDTH (PW),
      .DEPTH (DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (park),
      .wr_addr (free_idx),
      .wr_data (head_word.payload),
      .rd_en   (ram_rd_en),
      .rd_addr (hit_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid  = (state_ff == S_EMIT);
   assign rsp_word   = rsp_ff;
   assign stat_held  = held_ff;
   assign stat_valid = valid_ff;
   assign stat_last  = last_ff;

endmodule
